@@ rtl/core/rft_pkg.sv @@
package rft_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int INDEX_BITS     = 24;
	localparam int FRAC_BITS      = 8;
	localparam int LEVEL_BITS     = 16;
	localparam int PCT_BITS       = 7;
	localparam int POS_BITS       = 32;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;

	localparam int DIFF_BITS    = ((SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS) + 2;
	localparam int REM_BITS     = SAMPLE_BITS + 1;
	localparam int POS_SUM_BITS = INDEX_BITS + FRAC_BITS + 1;
	localparam int PROD_BITS    = PCT_BITS + LEVEL_BITS;
	localparam int DIV100_BITS  = 24;
	localparam int DIV100_SHIFT = 30;
	localparam int WIDE_BITS    = PROD_BITS + DIV100_BITS;

	localparam logic [DIV100_BITS-1:0] DIV100_MULT = 24'd10737419;
	localparam logic [PCT_BITS-1:0]    PCT_MAX     = 7'd100;
	localparam logic [PCT_BITS-1:0]    LOWER_PCT_RESET = 7'd10;
	localparam logic [PCT_BITS-1:0]    UPPER_PCT_RESET = 7'd90;

	localparam logic [1:0] CLS_BELOW = 2'd0;
	localparam logic [1:0] CLS_MID   = 2'd1;
	localparam logic [1:0] CLS_ABOVE = 2'd2;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_STATE_LOW  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_STATE_HIGH = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LOWER_PCT  = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_UPPER_PCT  = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          first;
	} sample_t;

	typedef struct packed {
		logic                rising;
		logic [POS_BITS-1:0] start_pos;
		logic [POS_BITS-1:0] end_pos;
		logic [POS_BITS-1:0] duration;
	} result_t;

	typedef struct packed {
		logic                         ok;
		logic                         enabled;
		logic signed [LEVEL_BITS-1:0] trail;
		logic signed [LEVEL_BITS-1:0] lead;
	} levels_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic                          do_start;
		logic signed [LEVEL_BITS-1:0]  start_lvl;
		logic                          do_emit;
		logic signed [LEVEL_BITS-1:0]  end_lvl;
		logic                          rising;
		logic signed [SAMPLE_BITS-1:0] a;
		logic signed [SAMPLE_BITS-1:0] b;
		logic [INDEX_BITS-1:0]         idx;
	} job_t;

endpackage

@@ rtl/core/rft_levels.sv @@
module rft_levels (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rft_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [rft_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output rft_pkg::levels_t                    levels
);

	logic signed [rft_pkg::LEVEL_BITS-1:0] state_low_q;
	logic signed [rft_pkg::LEVEL_BITS-1:0] state_high_q;
	logic [rft_pkg::PCT_BITS-1:0]          lower_pct_q;
	logic [rft_pkg::PCT_BITS-1:0]          upper_pct_q;
	logic [1:0]                            settle_q;

	logic [rft_pkg::LEVEL_BITS:0]          span;
	logic [rft_pkg::LEVEL_BITS-1:0]        range_u;
	logic [rft_pkg::PCT_BITS-1:0]          lower_sat;
	logic [rft_pkg::PCT_BITS-1:0]          upper_sat;

	logic [rft_pkg::PROD_BITS-1:0]         trail_prod_s1;
	logic [rft_pkg::PROD_BITS-1:0]         lead_prod_s1;
	logic [rft_pkg::WIDE_BITS-1:0]         trail_wide;
	logic [rft_pkg::WIDE_BITS-1:0]         lead_wide;
	logic [rft_pkg::LEVEL_BITS-1:0]        trail_off_s2;
	logic [rft_pkg::LEVEL_BITS-1:0]        lead_off_s2;
	logic [rft_pkg::LEVEL_BITS:0]          trail_sum;
	logic [rft_pkg::LEVEL_BITS:0]          lead_sum;
	logic [rft_pkg::LEVEL_BITS-1:0]        trail_s3;
	logic [rft_pkg::LEVEL_BITS-1:0]        lead_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_low_q  <= '0;
			state_high_q <= '0;
			lower_pct_q  <= rft_pkg::LOWER_PCT_RESET;
			upper_pct_q  <= rft_pkg::UPPER_PCT_RESET;
			settle_q     <= 2'd3;
		end else if (cfg_valid && cfg_ready) begin
			settle_q <= 2'd3;
			unique case (cfg_index)
				rft_pkg::CFG_STATE_LOW:  state_low_q  <= cfg_data;
				rft_pkg::CFG_STATE_HIGH: state_high_q <= cfg_data;
				rft_pkg::CFG_LOWER_PCT:  lower_pct_q  <= cfg_data[rft_pkg::PCT_BITS-1:0];
				rft_pkg::CFG_UPPER_PCT:  upper_pct_q  <= cfg_data[rft_pkg::PCT_BITS-1:0];
			endcase
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	assign span      = {state_high_q[rft_pkg::LEVEL_BITS-1], state_high_q}
	                 - {state_low_q[rft_pkg::LEVEL_BITS-1], state_low_q};
	assign range_u   = span[rft_pkg::LEVEL_BITS-1:0];
	assign lower_sat = (lower_pct_q > rft_pkg::PCT_MAX) ? rft_pkg::PCT_MAX : lower_pct_q;
	assign upper_sat = (upper_pct_q > rft_pkg::PCT_MAX) ? rft_pkg::PCT_MAX : upper_pct_q;

	assign trail_wide = rft_pkg::WIDE_BITS'(trail_prod_s1)
	                  * rft_pkg::WIDE_BITS'(rft_pkg::DIV100_MULT);
	assign lead_wide  = rft_pkg::WIDE_BITS'(lead_prod_s1)
	                  * rft_pkg::WIDE_BITS'(rft_pkg::DIV100_MULT);

	assign trail_sum = {state_low_q[rft_pkg::LEVEL_BITS-1], state_low_q} + {1'b0, trail_off_s2};
	assign lead_sum  = {state_low_q[rft_pkg::LEVEL_BITS-1], state_low_q} + {1'b0, lead_off_s2};

	always_ff @(posedge clk) begin
		trail_prod_s1 <= rft_pkg::PROD_BITS'(lower_sat) * rft_pkg::PROD_BITS'(range_u);
		lead_prod_s1  <= rft_pkg::PROD_BITS'(upper_sat) * rft_pkg::PROD_BITS'(range_u);
		trail_off_s2  <= trail_wide[rft_pkg::DIV100_SHIFT +: rft_pkg::LEVEL_BITS];
		lead_off_s2   <= lead_wide[rft_pkg::DIV100_SHIFT +: rft_pkg::LEVEL_BITS];
		trail_s3      <= trail_sum[rft_pkg::LEVEL_BITS-1:0];
		lead_s3       <= lead_sum[rft_pkg::LEVEL_BITS-1:0];
	end

	assign levels.ok      = (settle_q == 2'd0);
	assign levels.enabled = (state_high_q > state_low_q);
	assign levels.trail   = trail_s3;
	assign levels.lead    = lead_s3;

endmodule

@@ rtl/core/rft_front.sv @@
module rft_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rft_pkg::levels_t     levels,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  rft_pkg::sample_t     sample_data,
	input  rft_pkg::queue_stat_t q_stat,
	output logic                 push,
	output rft_pkg::job_t        push_job
);

	logic signed [rft_pkg::SAMPLE_BITS-1:0] prev_sample_q;
	logic [1:0]                             prev_class_q;
	logic                                   rise_armed_q;
	logic                                   fall_armed_q;
	logic [rft_pkg::INDEX_BITS-1:0]         index_q;
	logic                                   have_prev_q;

	logic signed [rft_pkg::DIFF_BITS-1:0] x_ext;
	logic signed [rft_pkg::DIFF_BITS-1:0] trail_ext;
	logic signed [rft_pkg::DIFF_BITS-1:0] lead_ext;
	logic                                 accept;
	logic                                 restart;
	logic [1:0]                           cls;
	logic                                 ra;
	logic                                 fa;
	logic                                 do_start;
	logic                                 do_emit;
	logic                                 rising;
	logic signed [rft_pkg::LEVEL_BITS-1:0] start_lvl;
	logic signed [rft_pkg::LEVEL_BITS-1:0] end_lvl;

	assign sample_stall = !levels.ok || q_stat.full;
	assign accept       = sample_valid && !sample_stall;
	assign restart      = sample_data.first || !have_prev_q;

	assign x_ext     = rft_pkg::DIFF_BITS'(sample_data.sample);
	assign trail_ext = rft_pkg::DIFF_BITS'(levels.trail);
	assign lead_ext  = rft_pkg::DIFF_BITS'(levels.lead);

	always_comb begin
		cls       = rft_pkg::CLS_BELOW;
		ra        = rise_armed_q;
		fa        = fall_armed_q;
		do_start  = 1'b0;
		do_emit   = 1'b0;
		rising    = 1'b0;
		start_lvl = levels.trail;
		end_lvl   = levels.trail;
		if (levels.enabled) begin
			if (x_ext <= trail_ext) begin
				cls = rft_pkg::CLS_BELOW;
			end else if (x_ext >= lead_ext) begin
				cls = rft_pkg::CLS_ABOVE;
			end else begin
				cls = rft_pkg::CLS_MID;
			end
			if (cls == rft_pkg::CLS_BELOW) begin
				ra = 1'b0;
				if (fa) begin
					do_emit = 1'b1;
					end_lvl = levels.trail;
					rising  = 1'b0;
					fa      = 1'b0;
				end
			end else if (cls == rft_pkg::CLS_ABOVE) begin
				fa = 1'b0;
				if (ra) begin
					do_emit = 1'b1;
					end_lvl = levels.lead;
					rising  = 1'b1;
					ra      = 1'b0;
				end
			end
			if (prev_class_q == rft_pkg::CLS_BELOW && cls != rft_pkg::CLS_BELOW && !ra) begin
				ra        = 1'b1;
				do_start  = 1'b1;
				start_lvl = levels.trail;
				if (cls == rft_pkg::CLS_ABOVE) begin
					do_emit = 1'b1;
					end_lvl = levels.lead;
					rising  = 1'b1;
					ra      = 1'b0;
				end
			end
			if (prev_class_q == rft_pkg::CLS_ABOVE && cls != rft_pkg::CLS_ABOVE && !fa) begin
				fa        = 1'b1;
				do_start  = 1'b1;
				start_lvl = levels.lead;
				if (cls == rft_pkg::CLS_BELOW) begin
					do_emit = 1'b1;
					end_lvl = levels.trail;
					rising  = 1'b0;
					fa      = 1'b0;
				end
			end
		end else begin
			ra = 1'b0;
			fa = 1'b0;
		end
	end

	assign push              = accept && !restart && (do_start || do_emit);
	assign push_job.do_start  = do_start;
	assign push_job.start_lvl = start_lvl;
	assign push_job.do_emit   = do_emit;
	assign push_job.end_lvl   = end_lvl;
	assign push_job.rising    = rising;
	assign push_job.a         = prev_sample_q;
	assign push_job.b         = sample_data.sample;
	assign push_job.idx       = index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_class_q <= rft_pkg::CLS_BELOW;
			rise_armed_q <= 1'b0;
			fall_armed_q <= 1'b0;
			index_q      <= '0;
			have_prev_q  <= 1'b0;
		end else if (accept) begin
			prev_class_q <= cls;
			have_prev_q  <= 1'b1;
			if (restart) begin
				index_q      <= '0;
				rise_armed_q <= 1'b0;
				fall_armed_q <= 1'b0;
			end else begin
				if (index_q != '1) begin
					index_q <= index_q + 1'b1;
				end
				rise_armed_q <= ra;
				fall_armed_q <= fa;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_sample_q <= sample_data.sample;
		end
	end

endmodule

@@ rtl/core/rft_queue.sv @@
module rft_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rft_pkg::job_t        push_job,
	input  logic                 pop,
	output rft_pkg::job_t        head_job,
	output rft_pkg::queue_stat_t q_stat
);

	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	rft_pkg::job_t         mem_q [DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [CNT_BITS-1:0]   count_q;

	assign q_stat.full  = (count_q == CNT_BITS'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head_job     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/rft_back.sv @@
module rft_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rft_pkg::queue_stat_t q_stat,
	input  rft_pkg::job_t        head_job,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output rft_pkg::result_t     result_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_POS  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	localparam int CNT_BITS = $clog2(rft_pkg::FRAC_BITS + 1);
	localparam logic [rft_pkg::FRAC_BITS:0] FRAC_ONE = {1'b1, {rft_pkg::FRAC_BITS{1'b0}}};

	logic [2:0]                          state_q;
	rft_pkg::job_t                       job_q;
	logic                                phase_end_q;
	logic [rft_pkg::REM_BITS-1:0]        rem_q;
	logic [rft_pkg::REM_BITS-1:0]        den_q;
	logic [rft_pkg::FRAC_BITS:0]         frac_q;
	logic [CNT_BITS-1:0]                 cnt_q;
	logic [rft_pkg::POS_BITS-1:0]        pending_start_q;
	logic [rft_pkg::POS_BITS-1:0]        end_pos_q;
	logic                                result_valid_q;
	rft_pkg::result_t                    result_q;

	logic signed [rft_pkg::LEVEL_BITS-1:0] lvl;
	logic signed [rft_pkg::DIFF_BITS-1:0]  a_ext;
	logic signed [rft_pkg::DIFF_BITS-1:0]  b_ext;
	logic signed [rft_pkg::DIFF_BITS-1:0]  l_ext;
	logic signed [rft_pkg::DIFF_BITS-1:0]  diff_raw;
	logic signed [rft_pkg::DIFF_BITS-1:0]  num_raw;
	logic signed [rft_pkg::DIFF_BITS-1:0]  diff_abs;
	logic signed [rft_pkg::DIFF_BITS-1:0]  num_abs;
	logic [rft_pkg::REM_BITS-1:0]          rem_dbl;
	logic                                  rem_ge;
	logic [rft_pkg::POS_SUM_BITS-1:0]      pos_sum;
	logic [rft_pkg::POS_BITS-1:0]          pos;
	logic                                  out_free;
	logic [rft_pkg::POS_BITS-1:0]          dur;

	assign pop = (state_q == ST_IDLE) && !q_stat.empty;

	assign lvl      = phase_end_q ? job_q.end_lvl : job_q.start_lvl;
	assign a_ext    = rft_pkg::DIFF_BITS'(job_q.a);
	assign b_ext    = rft_pkg::DIFF_BITS'(job_q.b);
	assign l_ext    = rft_pkg::DIFF_BITS'(lvl);
	assign diff_raw = b_ext - a_ext;
	assign num_raw  = l_ext - a_ext;
	assign diff_abs = diff_raw[rft_pkg::DIFF_BITS-1] ? -diff_raw : diff_raw;
	assign num_abs  = diff_raw[rft_pkg::DIFF_BITS-1] ? -num_raw : num_raw;

	assign rem_dbl = {rem_q[rft_pkg::REM_BITS-2:0], 1'b0};
	assign rem_ge  = (rem_dbl >= den_q);

	assign pos_sum = {1'b0, job_q.idx, {rft_pkg::FRAC_BITS{1'b0}}}
	               + rft_pkg::POS_SUM_BITS'(frac_q);
	assign pos     = (|pos_sum[rft_pkg::POS_SUM_BITS-1:rft_pkg::POS_BITS])
	               ? '1 : pos_sum[rft_pkg::POS_BITS-1:0];

	assign out_free = !result_valid_q || !result_stall;
	assign dur      = (end_pos_q >= pending_start_q) ? end_pos_q - pending_start_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall && state_q != ST_EMIT) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (diff_abs == '0 || num_abs[rft_pkg::DIFF_BITS-1] || num_abs == '0
					    || num_abs >= diff_abs) begin
						state_q <= ST_POS;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_BITS'(1)) begin
						state_q <= ST_POS;
					end
				end
				ST_POS: begin
					if (phase_end_q) begin
						state_q <= ST_EMIT;
					end else if (job_q.do_emit) begin
						state_q <= ST_PREP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (pop) begin
					job_q       <= head_job;
					phase_end_q <= !head_job.do_start;
				end
			end
			ST_PREP: begin
				rem_q  <= num_abs[rft_pkg::REM_BITS-1:0];
				den_q  <= diff_abs[rft_pkg::REM_BITS-1:0];
				cnt_q  <= CNT_BITS'(rft_pkg::FRAC_BITS);
				if (diff_abs == '0 || num_abs[rft_pkg::DIFF_BITS-1] || num_abs == '0) begin
					frac_q <= '0;
				end else if (num_abs >= diff_abs) begin
					frac_q <= FRAC_ONE;
				end else begin
					frac_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q  <= rem_ge ? rem_dbl - den_q : rem_dbl;
				frac_q <= {frac_q[rft_pkg::FRAC_BITS-1:0], rem_ge};
				cnt_q  <= cnt_q - 1'b1;
			end
			ST_POS: begin
				if (phase_end_q) begin
					end_pos_q <= pos;
				end else begin
					pending_start_q <= pos;
					phase_end_q     <= 1'b1;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					result_q.rising    <= job_q.rising;
					result_q.start_pos <= pending_start_q;
					result_q.end_pos   <= end_pos_q;
					result_q.duration  <= dur;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

endmodule

@@ rtl/core/rise_fall_transition_detector_top.sv @@
// Rise and fall transition detector for sampled records.
// Samples enter on the sample channel (valid/stall), one beat per sample; a
// set first bit starts a new record. Results leave on the result channel
// (valid/stall), one beat per detected rising or falling edge, carrying the
// two reference crossings in Q24.8 sample units and their difference.
// Configuration beats (valid/ready) write the state levels and percentages;
// write them only while the block is idle. After a write and after reset,
// the sample channel stalls while the reference levels are recomputed
// through a three-stage multiply pipeline. The front takes one sample per
// cycle unless stalled and queues crossing jobs. The back interpolates each
// crossing with a restoring divider, one quotient bit per cycle: a crossing
// passes a prepare state, the divide state (skipped for a fraction of 0 or
// 1) and a position state (one crossing for an armed edge, two for a jump
// across both levels), and a job with an edge ends in the emit state. Apart
// from that settling, the sample channel stalls only when QUEUE_DEPTH jobs
// are waiting. A stalled result holds in the output register while the back
// goes on with the next job up to its result.
// Reset clears the record state, the queue and the output valid.
module rise_fall_transition_detector_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  rft_pkg::sample_t                   sample_data,
	output logic                               result_valid,
	input  logic                               result_stall,
	output rft_pkg::result_t                   result_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rft_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [rft_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	rft_pkg::levels_t     levels;
	rft_pkg::queue_stat_t q_stat;
	rft_pkg::job_t        push_job;
	rft_pkg::job_t        head_job;
	logic                 push;
	logic                 pop;

	rft_levels u_levels (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.levels    (levels)
	);

	rft_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.levels       (levels),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_data  (sample_data),
		.q_stat       (q_stat),
		.push         (push),
		.push_job     (push_job)
	);

	rft_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.q_stat   (q_stat)
	);

	rft_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.head_job     (head_job),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule

@@ rtl/core/rft_checker.sv @@
module rft_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             cfg_valid,
	input logic             cfg_ready,
	input logic             sample_stall,
	input logic             result_valid,
	input logic             result_stall,
	input rft_pkg::result_t result_data
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_data))
		else $error("stalled result beat changed");

	a_duration_diff: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_data.end_pos >= result_data.start_pos)
		|-> result_data.duration == result_data.end_pos - result_data.start_pos)
		else $error("duration differs from end minus start");

	a_duration_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_data.end_pos < result_data.start_pos)
		|-> result_data.duration == '0)
		else $error("negative duration not reported as zero");

	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> sample_stall)
		else $error("sample accepted before levels settled");

endmodule

bind rise_fall_transition_detector_top rft_checker u_rft_checker (.*);

@@ dv/rft_edge_checker.sv @@
module rft_edge_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	input  logic                               sample_stall,
	input  rft_pkg::sample_t                   sample_data,
	input  logic                               result_valid,
	input  logic                               result_stall,
	input  rft_pkg::result_t                   result_data,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [rft_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [rft_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output int                                 fail_count,
	output int                                 edges_waiting,
	output int                                 samples_taken,
	output int                                 edges_checked
);
	import rft_pkg::*;

	localparam longint IDX_MAX  = (longint'(1) << INDEX_BITS) - 1;
	localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;

	longint              lvl_low;
	longint              lvl_high;
	int                  pct_lower;
	int                  pct_upper;
	longint              last_sample;
	longint              last_index;
	logic [1:0]          last_class;
	logic                rise_open;
	logic                fall_open;
	logic [POS_BITS-1:0] open_start;
	logic                have_last;
	int                  fails;
	int                  taken;
	int                  checked;
	result_t             expected_edges[$];

	function automatic longint ref_point(int pct, longint range);
		int p;
		p = (pct > 100) ? 100 : pct;
		return lvl_low + (longint'(p) * range) / 100;
	endfunction

	function automatic logic [1:0] class_of(longint v, longint trail, longint lead);
		if (v <= trail) begin
			return CLS_BELOW;
		end
		if (v >= lead) begin
			return CLS_ABOVE;
		end
		return CLS_MID;
	endfunction

	function automatic logic [POS_BITS-1:0] cross_point(longint idx, longint a, longint b,
			longint lvl);
		longint d;
		longint num;
		longint frac;
		longint pos;
		d = b - a;
		num = lvl - a;
		frac = 0;
		if (d != 0) begin
			if (d < 0) begin
				d = -d;
				num = -num;
			end
			if (num <= 0) begin
				frac = 0;
			end else if (num >= d) begin
				frac = FRAC_ONE;
			end else begin
				frac = (num << FRAC_BITS) / d;
			end
		end
		pos = (idx << FRAC_BITS) + frac;
		return (pos > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pos[31:0];
	endfunction

	task automatic apply_write(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		case (idx)
			CFG_STATE_LOW: begin
				lvl_low = longint'($signed(value));
			end
			CFG_STATE_HIGH: begin
				lvl_high = longint'($signed(value));
			end
			CFG_LOWER_PCT: begin
				pct_lower = int'(value[PCT_BITS-1:0]);
			end
			CFG_UPPER_PCT: begin
				pct_upper = int'(value[PCT_BITS-1:0]);
			end
			default: begin
			end
		endcase
	endtask

	task automatic predict_edge(input sample_t item);
		longint              x;
		longint              range;
		longint              trail;
		longint              lead;
		longint              prev_idx;
		logic [1:0]          cls;
		logic                enabled;
		logic                emit;
		logic                up;
		logic [POS_BITS-1:0] end_mark;
		result_t             res;
		x = longint'($signed(item.sample));
		enabled = lvl_high > lvl_low;
		range = lvl_high - lvl_low;
		trail = 0;
		lead = 0;
		emit = 1'b0;
		up = 1'b0;
		end_mark = '0;
		taken++;
		if (enabled) begin
			trail = ref_point(pct_lower, range);
			lead = ref_point(pct_upper, range);
			cls = class_of(x, trail, lead);
		end else begin
			cls = CLS_BELOW;
		end
		if (item.first || !have_last) begin
			last_index = 0;
			rise_open = 1'b0;
			fall_open = 1'b0;
			last_sample = x;
			last_class = cls;
			have_last = 1'b1;
		end else begin
			prev_idx = last_index;
			last_index = (prev_idx >= IDX_MAX) ? IDX_MAX : prev_idx + 1;
			if (!enabled) begin
				rise_open = 1'b0;
				fall_open = 1'b0;
			end else begin
				if (cls == CLS_BELOW) begin
					rise_open = 1'b0;
					if (fall_open) begin
						end_mark = cross_point(prev_idx, last_sample, x, trail);
						up = 1'b0;
						emit = 1'b1;
						fall_open = 1'b0;
					end
				end else if (cls == CLS_ABOVE) begin
					fall_open = 1'b0;
					if (rise_open) begin
						end_mark = cross_point(prev_idx, last_sample, x, lead);
						up = 1'b1;
						emit = 1'b1;
						rise_open = 1'b0;
					end
				end
				if (last_class == CLS_BELOW && cls != CLS_BELOW && !rise_open) begin
					rise_open = 1'b1;
					open_start = cross_point(prev_idx, last_sample, x, trail);
					if (cls == CLS_ABOVE) begin
						end_mark = cross_point(prev_idx, last_sample, x, lead);
						up = 1'b1;
						emit = 1'b1;
						rise_open = 1'b0;
					end
				end
				if (last_class == CLS_ABOVE && cls != CLS_ABOVE && !fall_open) begin
					fall_open = 1'b1;
					open_start = cross_point(prev_idx, last_sample, x, lead);
					if (cls == CLS_BELOW) begin
						end_mark = cross_point(prev_idx, last_sample, x, trail);
						up = 1'b0;
						emit = 1'b1;
						fall_open = 1'b0;
					end
				end
			end
			last_sample = x;
			last_class = cls;
			if (emit) begin
				res.rising = up;
				res.start_pos = open_start;
				res.end_pos = end_mark;
				res.duration = (end_mark >= open_start) ? end_mark - open_start : '0;
				expected_edges.insert(expected_edges.size(), res);
			end
		end
	endtask

	task automatic check_edge(input result_t got);
		result_t want;
		if (expected_edges.size() == 0) begin
			fails++;
			if (fails <= 10) begin
				$display("unexpected edge beat: rising %0b start %h end %h duration %h",
					got.rising, got.start_pos, got.end_pos, got.duration);
			end
		end else begin
			want = expected_edges.pop_front();
			checked++;
			if (got.rising !== want.rising || got.start_pos !== want.start_pos ||
					got.end_pos !== want.end_pos || got.duration !== want.duration) begin
				fails++;
				if (fails <= 10) begin
					$display("edge %0d mismatch: expected rising %0b start %h end %h duration %h",
						checked, want.rising, want.start_pos, want.end_pos, want.duration);
					$display("edge %0d mismatch: actual   rising %0b start %h end %h duration %h",
						checked, got.rising, got.start_pos, got.end_pos, got.duration);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_low = 0;
			lvl_high = 0;
			pct_lower = int'(LOWER_PCT_RESET);
			pct_upper = int'(UPPER_PCT_RESET);
			last_sample = 0;
			last_index = 0;
			last_class = CLS_BELOW;
			rise_open = 1'b0;
			fall_open = 1'b0;
			open_start = '0;
			have_last = 1'b0;
			fails = 0;
			taken = 0;
			checked = 0;
			expected_edges.delete();
			fail_count <= 0;
			edges_waiting <= 0;
			samples_taken <= 0;
			edges_checked <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				check_edge(result_data);
			end
			if (cfg_valid && cfg_ready) begin
				apply_write(cfg_index, cfg_data);
			end
			if (sample_valid && !sample_stall) begin
				predict_edge(sample_data);
			end
			fail_count <= fails;
			edges_waiting <= expected_edges.size();
			samples_taken <= taken;
			edges_checked <= checked;
		end
	end

endmodule

@@ dv/rise_fall_transition_detector_top_test.sv @@
module rise_fall_transition_detector_top_test;
	import rft_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 68;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      sample_valid = 1'b0;
	logic                      sample_stall;
	sample_t                   sample_data  = '0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	result_t                   result_data;
	logic                      cfg_valid    = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

	int fail_count;
	int edges_waiting;
	int samples_taken;
	int edges_checked;
	int cycles       = 0;
	int stall_left   = 0;
	int hold_draw    = 0;
	int settings_run = 0;
	bit send_idle    = 1'b1;
	bit hold_idle    = 1'b1;

	always #5 clk = ~clk;

	rise_fall_transition_detector_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_data  (sample_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	rft_edge_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample_data   (sample_data),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result_data   (result_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.edges_waiting (edges_waiting),
		.samples_taken (samples_taken),
		.edges_checked (edges_checked)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("rise_fall_transition_detector_top regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_stall <= (stall_left > 1);
		end else if (result_valid && !result_stall) begin
			if ($urandom_range(0, 24) == 0) begin
				hold_idle = !hold_idle;
			end
			hold_draw = hold_idle ? $urandom_range(0, 14) : 0;
			stall_left <= hold_draw;
			result_stall <= (hold_draw != 0);
		end
	end

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] value, input logic starts);
		int gap;
		if ($urandom_range(0, 29) == 0) begin
			send_idle = !send_idle;
		end
		gap = send_idle ? $urandom_range(0, 14) : 0;
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_data <= '{sample: value, first: starts};
		// hold the beat until taken
		do @(posedge clk); while (sample_stall);
	endtask

	task automatic settle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (edges_waiting != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic write_levels(input logic [15:0] lo, input logic [15:0] hi,
			input logic [15:0] lp, input logic [15:0] up);
		write_reg(CFG_STATE_LOW, lo);
		write_reg(CFG_STATE_HIGH, hi);
		write_reg(CFG_LOWER_PCT, lp);
		write_reg(CFG_UPPER_PCT, up);
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	initial begin
		logic [15:0]            lo;
		logic [15:0]            hi;
		logic [15:0]            lp;
		logic [15:0]            up;
		logic [SAMPLE_BITS-1:0] value;
		logic                   starts;
		bit                     heading_up;
		int                     kind;
		int                     l;
		int                     r;
		int                     roll;
		int                     step;
		int                     wave;
		int                     base;
		int                     span;
		int                     top_lim;
		int                     bot_lim;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// levels at reset are disabled
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h0000, 1'b1);
		settle();

		// upper percent above 100 saturates
		write_levels(16'd0, 16'd1000, 16'd10, 16'd120);
		send_sample(16'd0, 1'b1);
		send_sample(16'd500, 1'b0);
		send_sample(16'd1000, 1'b0);
		send_sample(16'd500, 1'b0);
		send_sample(16'd0, 1'b0);
		send_sample(16'd1000, 1'b0);
		send_sample(16'd0, 1'b0);
		send_sample(16'd500, 1'b0);
		send_sample(16'd0, 1'b0);
		send_sample(16'd500, 1'b0);
		send_sample(16'd500, 1'b0);
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'd1000, 1'b0);
		send_sample(16'd100, 1'b0);
		send_sample(16'd500, 1'b0);
		send_sample(16'd1000, 1'b1);
		settle();

		// full range with crossed levels
		write_levels(16'h8000, 16'h7FFF, 16'd70, 16'd30);
		send_sample(16'd0, 1'b1);
		send_sample(16'd20000, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'd13106, 1'b0);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			kind = $urandom_range(0, 9);
			case (kind)
				0: begin
					lo = 16'($urandom);
					hi = 16'($urandom);
				end
				1: begin
					lo = 16'h8000;
					hi = 16'h7FFF;
				end
				2: begin
					lo = 16'($urandom);
					hi = lo;
				end
				default: begin
					l = $urandom_range(0, 50000) - 32768;
					r = $urandom_range(20, 12000);
					lo = l[15:0];
					hi = 16'(l + r);
				end
			endcase
			kind = $urandom_range(0, 7);
			case (kind)
				0: begin
					lp = 16'($urandom);
					up = 16'($urandom);
				end
				1: begin
					lp = 16'd100;
					up = 16'd0;
				end
				2: begin
					lp = 16'd0;
					up = 16'd100;
				end
				3: begin
					lp = 16'($urandom_range(101, 127));
					up = 16'($urandom_range(101, 127));
				end
				4: begin
					lp = 16'($urandom_range(50, 100));
					up = 16'($urandom_range(0, 50));
				end
				default: begin
					lp = 16'($urandom_range(0, 40));
					up = 16'($urandom_range(60, 100));
				end
			endcase
			write_levels(lo, hi, lp, up);

			l = int'($signed(lo));
			r = int'($signed(hi));
			base = l;
			span = (r > l) ? r - l : 2000;
			top_lim = base + span + span / 16;
			bot_lim = base - span / 16;
			if (top_lim > 32767) begin
				top_lim = 32767;
			end
			if (bot_lim < -32768) begin
				bot_lim = -32768;
			end
			wave = base;
			heading_up = 1'b1;

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				starts = ($urandom_range(0, 49) == 0);
				roll = $urandom_range(0, 99);
				if (roll < 6) begin
					value = SAMPLE_BITS'($urandom);
				end else begin
					if (roll < 12) begin
						heading_up = !heading_up;
					end
					if (roll >= 12 && roll < 18) begin
						wave = heading_up ? top_lim : bot_lim;
					end else if (roll >= 26) begin
						step = $urandom_range(1, span / 3 + 1);
						wave = heading_up ? wave + step : wave - step;
					end
					if (wave >= top_lim) begin
						wave = top_lim;
						heading_up = 1'b0;
					end
					if (wave <= bot_lim) begin
						wave = bot_lim;
						heading_up = 1'b1;
					end
					value = wave[15:0];
				end
				send_sample(value, starts);
			end
		end

		settle();
		$display("covered %0d samples over %0d level settings, %0d edge beats checked",
			samples_taken, settings_run, edges_checked);
		$display("waveforms swept ramps, jumps, plateaus, cancels and record restarts");
		if (fail_count == 0 && edges_waiting == 0) begin
			$display("rise_fall_transition_detector_top regression: pass");
		end else begin
			$display("rise_fall_transition_detector_top regression: fail");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/rft_pkg.sv
rtl/core/rft_levels.sv
rtl/core/rft_front.sv
rtl/core/rft_queue.sv
rtl/core/rft_back.sv
rtl/core/rise_fall_transition_detector_top.sv
rtl/core/rft_checker.sv
dv/rft_edge_checker.sv
dv/rise_fall_transition_detector_top_test.sv
